// ===== rtl/core/utf8gi_pkg.sv =====
// Shared types and constants for the UTF-8 glyph index decoder.
`default_nettype none

package utf8gi_pkg;

   // Operation carried in the request tuser field.
   typedef enum logic [1:0] {
      OP_TEXT     = 2'd0,
      OP_WR_HIGH  = 2'd1,
      OP_WR_LOW   = 2'd2
   } opcode_type;

   // Field widths.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CODE_W   = 16;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned OFFSET_W = 22;
   localparam int unsigned TBL_DEPTH = 256;

   // Lead byte classification masks and patterns.
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LOW6_MASK  = 8'h3F;
   localparam logic [7:0] LOW5_MASK  = 8'h1F;
   localparam logic [7:0] LOW4_MASK  = 8'h0F;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ===== rtl/core/utf8_glyph_index_decoder_top.sv =====
// Top level of the UTF-8 glyph index decoder: byte decode, table memories and offset pipeline.
//
// A completed character or terminator passes through the stage 1, stage 2 and output registers
// before it is presented on rsp; a held result stalls the whole pipeline.
// Throughput: one request transfer per cycle unless a held result or the clearing pass stalls
// requests; the table memories have one read and one write port each, and the offset multiply
// is split over two registered stages. Reset: synchronous, clears decode state and the pipeline,
// then a clearing pass zeroes all 256 entries of both tables while req_tready is held low.
`default_nettype none

module utf8_glyph_index_decoder_top #(
   parameter int unsigned GLYPH_BYTES = 34
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // text_byte[7:0], table_addr[15:8], table_value[23:16]
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // glyph_offset[21:0], char_count[37:22], zero[39:38]
   output logic             rsp_tlast    // string_end
);
   import utf8gi_pkg::*;

   localparam int unsigned GB_W   = $clog2(GLYPH_BYTES + 1);
   localparam int unsigned PROD_W = 2 * BYTE_W + GB_W;
   localparam logic [GB_W-1:0] GB_CONST = GB_W'(GLYPH_BYTES);

   // Request fields.
   opcode_type          req_op;
   logic [BYTE_W-1:0]   text_byte;
   logic [BYTE_W-1:0]   table_addr;
   logic [BYTE_W-1:0]   table_value;

   assign req_op      = opcode_type'(req_tuser);
   assign text_byte   = req_tdata[7:0];
   assign table_addr  = req_tdata[15:8];
   assign table_value = req_tdata[23:16];

   // Table clearing pass after reset.
   logic                clr_busy_ff;
   logic [BYTE_W-1:0]   clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == BYTE_W'(TBL_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Pipeline advance: everything moves when the output register is free or being drained.
   logic advance;
   logic req_xfer;
   logic rsp_vld_ff;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance && !clr_busy_ff;
   assign req_xfer   = req_tvalid && req_tready;

   // Decode state.
   logic [1:0]         pending_ff, pending_in;
   logic [CODE_W-1:0]  accum_ff,   accum_in;
   logic [COUNT_W-1:0] chars_ff,   chars_in;

   // Decode results for the current transfer.
   logic               emit;
   logic               emit_end;
   logic               wr_high;
   logic               wr_low;
   logic [CODE_W-1:0]  cont_accum;

   assign cont_accum = {accum_ff[CODE_W-7:0], text_byte[5:0]};

   // Byte decode and next decode state.
   always_comb begin
      pending_in = pending_ff;
      accum_in   = accum_ff;
      chars_in   = chars_ff;
      emit       = 1'b0;
      emit_end   = 1'b0;
      wr_high    = 1'b0;
      wr_low     = 1'b0;
      if (req_xfer) begin
         unique case (req_op)
            OP_WR_HIGH: wr_high = 1'b1;
            OP_WR_LOW:  wr_low  = 1'b1;
            OP_TEXT: begin
               priority if (text_byte == '0) begin
                  // Terminator reports the count and starts a new string.
                  emit       = 1'b1;
                  emit_end   = 1'b1;
                  pending_in = '0;
                  accum_in   = '0;
                  chars_in   = '0;
               end else if (pending_ff != '0) begin
                  // Continuation byte adds six code bits.
                  accum_in   = cont_accum;
                  pending_in = pending_ff - 2'd1;
                  emit       = (pending_ff == 2'd1);
               end else if ((text_byte & LEAD4_MASK) == LEAD4_PAT) begin
                  accum_in   = '0;
                  pending_in = 2'd3;
               end else if ((text_byte & LEAD3_PAT) == LEAD3_PAT) begin
                  accum_in   = CODE_W'(text_byte & LOW4_MASK);
                  pending_in = 2'd2;
               end else if ((text_byte & LEAD2_PAT) == LEAD2_PAT) begin
                  accum_in   = CODE_W'(text_byte & LOW5_MASK);
                  pending_in = 2'd1;
               end else begin
                  // ASCII or stray continuation byte is a whole character.
                  accum_in   = CODE_W'(text_byte);
                  emit       = 1'b1;
               end
               if (emit && !emit_end && chars_ff != COUNT_MAX) begin
                  chars_in = chars_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         accum_ff   <= '0;
         chars_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
         chars_ff   <= chars_in;
      end
   end

   // Table memories with one write and one registered read port each.
   logic [BYTE_W-1:0]    high_mem [TBL_DEPTH];
   logic [BYTE_W-1:0]    low_mem  [TBL_DEPTH];
   logic [BYTE_W-1:0]    s1_high_ff;
   logic [BYTE_W-1:0]    s1_low_ff;
   logic                 rd_en;

   assign rd_en = advance && emit && !emit_end;

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         high_mem[clr_addr_ff] <= '0;
         low_mem[clr_addr_ff]  <= '0;
      end else begin
         if (wr_high) begin
            high_mem[table_addr] <= table_value;
         end
         if (wr_low) begin
            low_mem[table_addr] <= table_value;
         end
      end
      if (rd_en) begin
         s1_high_ff <= high_mem[accum_in[15:8]];
         s1_low_ff  <= low_mem[accum_in[7:0]];
      end
   end

   // Stage 1 control: result kind and count.
   logic               s1_vld_ff;
   logic               s1_end_ff;
   logic [COUNT_W-1:0] s1_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_end_ff   <= emit_end;
         s1_count_ff <= emit_end ? chars_ff : chars_in;
      end
   end

   // Stage 2: product of the two table entries.
   logic                  s2_vld_ff;
   logic                  s2_end_ff;
   logic [COUNT_W-1:0]    s2_count_ff;
   logic [2*BYTE_W-1:0]   s2_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_end_ff   <= s1_end_ff;
         s2_count_ff <= s1_count_ff;
         s2_prod_ff  <= s1_end_ff ? '0 : s1_high_ff * s1_low_ff;
      end
   end

   // Stage 3: scale by the glyph size into the output register.
   logic [PROD_W-1:0]   scaled;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_end_ff;

   assign scaled = PROD_W'(s2_prod_ff) * PROD_W'(GB_CONST);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_offset_ff <= OFFSET_W'(scaled);
         rsp_count_ff  <= s2_count_ff;
         rsp_end_ff    <= s2_end_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_offset_ff};
   assign rsp_tlast  = rsp_end_ff;

`ifndef ASSERT_OFF
   // A terminator leaves no partial character behind.
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (emit_end) |=> (pending_ff == '0 && chars_ff == '0))
      else $error("terminator did not clear decode state");

   // End results carry a zero offset.
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_offset_ff == '0))
      else $error("end result with nonzero offset");

   // A glyph result always counts at least one character.
   a_glyph_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_count_ff != '0))
      else $error("glyph result with zero count");

   // The count saturates instead of wrapping.
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      (chars_ff == COUNT_MAX && !emit_end) |=> (chars_ff == COUNT_MAX))
      else $error("character count wrapped");

   // Table reads only happen for completed characters.
   a_read_kind: assert property (@(posedge clock) disable iff (reset)
      (rd_en) |=> (s1_vld_ff && !s1_end_ff))
      else $error("table read without a glyph in stage one");
`endif

endmodule

`default_nettype wire
